// ===== rtl/chroma_median3x3_filter_unit_defines.svh =====
// Assertion macros for the chroma median filter; expect clk and arst_n in scope.
`ifndef CHROMA_MEDIAN3X3_FILTER_UNIT_DEFINES_SVH
`define CHROMA_MEDIAN3X3_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CHM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/chm_pkg.sv =====
// Shared constants, types and codes of the chroma median filter.
package chm_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WEFF_W = COL_W + 1;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int SAMPLE_W = 8;
	localparam int IN_ROW_W = 13;
	localparam int OUT_ROW_W = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [2*SAMPLE_W-1:0] uv_t;
	typedef uv_t [8:0] window_t;
	typedef sample_t [8:0] plane_win_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} ctrl_t;

	typedef struct packed {
		sample_t med;
		sample_t ctr;
	} lane_res_t;

	typedef struct packed {
		sample_t u;
		sample_t v;
		logic    last;
	} res_t;

endpackage

// ===== rtl/chm_if.sv =====
// Valid/ready channel interfaces for pixel items and result items.
interface chm_in_if;
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic [chm_pkg::SAMPLE_W-1:0]     u_in;
	logic [chm_pkg::SAMPLE_W-1:0]     v_in;

	modport source (output valid, req_type, u_in, v_in, input ready);
	modport sink (input valid, req_type, u_in, v_in, output ready);
endinterface

interface chm_out_if;
	logic                             valid;
	logic                             ready;
	logic [chm_pkg::SAMPLE_W-1:0]     u_out;
	logic [chm_pkg::SAMPLE_W-1:0]     v_out;
	logic                             frame_last;

	modport source (output valid, u_out, v_out, frame_last, input ready);
	modport sink (input valid, u_out, v_out, frame_last, output ready);
endinterface

// ===== rtl/chm_line_store.sv =====
// Two-line store and 3x3 window registers holding packed U,V samples.
module chm_line_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          acc,
	input  logic [chm_pkg::COL_W-1:0]     col,
	input  chm_pkg::uv_t                  sample,
	output chm_pkg::window_t              window
);

	localparam int UV_W = $bits(chm_pkg::uv_t);

	// Each entry holds {older line, newer line} for one column.
	logic [2*UV_W-1:0] mem [chm_pkg::MAX_WIDTH];

	logic                        v_s1;
	logic [chm_pkg::COL_W-1:0]   col_s1;
	chm_pkg::uv_t                sample_s1;
	logic [2*UV_W-1:0]           rd_s1;
	logic                        byp_s1;
	logic [2*UV_W-1:0]           byp_data_s1;
	chm_pkg::window_t            window_q;

	logic [2*UV_W-1:0]           entry;
	chm_pkg::uv_t                older;
	chm_pkg::uv_t                newer;

	// Write of the item in s1 lands on the same edge as the next item's read, which so sees the old entry: forward it.
	assign entry = byp_s1 ? byp_data_s1 : rd_s1;
	assign older = entry[2*UV_W-1:UV_W];
	assign newer = entry[UV_W-1:0];

	always_ff @(posedge clk) begin
		rd_s1 <= mem[col];
		if (v_s1) begin
			mem[col_s1] <= {newer, sample_s1};
		end
	end

	always_ff @(posedge clk) begin
		col_s1      <= col;
		sample_s1   <= sample;
		byp_data_s1 <= {newer, sample_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
		end else begin
			v_s1   <= acc;
			byp_s1 <= acc && v_s1 && (col_s1 == col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r*3+0] <= window_q[r*3+1];
				window_q[r*3+1] <= window_q[r*3+2];
			end
			window_q[2] <= older;
			window_q[5] <= newer;
			window_q[8] <= sample_s1;
		end
	end

	assign window = window_q;

endmodule

// ===== rtl/chm_median_lane.sv =====
// Three-stage exact median of a 3x3 window for one chroma plane.
module chm_median_lane (
	input  logic                  clk,
	input  chm_pkg::plane_win_t   win,
	output chm_pkg::lane_res_t    res
);

	function automatic chm_pkg::sample_t min2(chm_pkg::sample_t a, chm_pkg::sample_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic chm_pkg::sample_t max2(chm_pkg::sample_t a, chm_pkg::sample_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic chm_pkg::sample_t med3(chm_pkg::sample_t a, chm_pkg::sample_t b,
		chm_pkg::sample_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	chm_pkg::sample_t mn_s3 [3];
	chm_pkg::sample_t md_s3 [3];
	chm_pkg::sample_t mx_s3 [3];
	chm_pkg::sample_t ctr_s3;
	chm_pkg::sample_t lo_s4;
	chm_pkg::sample_t mid_s4;
	chm_pkg::sample_t hi_s4;
	chm_pkg::sample_t ctr_s4;
	chm_pkg::sample_t med_s5;
	chm_pkg::sample_t ctr_s5;

	// Sort each row, then median of (max of mins, med of meds, min of maxes).
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			mn_s3[r] <= min2(min2(win[r*3], win[r*3+1]), win[r*3+2]);
			md_s3[r] <= med3(win[r*3], win[r*3+1], win[r*3+2]);
			mx_s3[r] <= max2(max2(win[r*3], win[r*3+1]), win[r*3+2]);
		end
		ctr_s3 <= win[4];

		lo_s4  <= max2(max2(mn_s3[0], mn_s3[1]), mn_s3[2]);
		mid_s4 <= med3(md_s3[0], md_s3[1], md_s3[2]);
		hi_s4  <= min2(min2(mx_s3[0], mx_s3[1]), mx_s3[2]);
		ctr_s4 <= ctr_s3;

		med_s5 <= med3(lo_s4, mid_s4, hi_s4);
		ctr_s5 <= ctr_s4;
	end

	assign res.med = med_s5;
	assign res.ctr = ctr_s5;

endmodule

// ===== rtl/chm_out_queue.sv =====
// Merge of the U and V lanes with the border select, and the result queue.
module chm_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	input  chm_pkg::ctrl_t        ctrl,
	input  chm_pkg::lane_res_t    u_res,
	input  chm_pkg::lane_res_t    v_res,
	output logic                  pop,
	chm_out_if.source             result
);

	chm_pkg::res_t                  queue_q [chm_pkg::QUEUE_DEPTH];
	logic [chm_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [chm_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [chm_pkg::QCNT_W-1:0]     cnt_q;
	chm_pkg::res_t                  entry;
	logic                           push;

	assign push = valid && ctrl.emit;

	// Border pixels keep their own sample.
	always_comb begin
		entry.u    = ctrl.border ? u_res.ctr : u_res.med;
		entry.v    = ctrl.border ? v_res.ctr : v_res.med;
		entry.last = ctrl.last;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + chm_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + chm_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + chm_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - chm_pkg::QCNT_W'(1);
			end
		end
	end

	assign result.valid      = (cnt_q != '0);
	assign result.u_out      = queue_q[rd_ptr_q].u;
	assign result.v_out      = queue_q[rd_ptr_q].v;
	assign result.frame_last = queue_q[rd_ptr_q].last;
	assign pop               = result.valid && result.ready;

endmodule

// ===== rtl/chroma_median3x3_filter_unit.sv =====
// Top level of the streaming 3x3 chroma median filter.

// The filter takes one pixel item per clock while pixel.ready is high. Each item does one read
// and one write of the two-line store (a single memory of MAX_WIDTH entries, one per column)
// and enters a fixed three-stage median network, one copy for U and one for V. The result
// for an emitting item runs alongside the control stages s1 to s5 and is then pushed into the
// output queue, from which it is offered; results trail the pixels by one frame row plus one
// pixel, so frame_width+1 drain items flush a frame. Ready drops only when eight items are
// in flight or waiting in the output queue. The line store needs no clearing after reset.
`include "chroma_median3x3_filter_unit_defines.svh"

module chroma_median3x3_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [chm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [chm_pkg::CFG_W-1:0]         cfg_data,
	chm_in_if.sink                            pixel,
	chm_out_if.source                         result
);

	logic [chm_pkg::CFG_W-1:0]      frame_width_q;
	logic [chm_pkg::CFG_W-1:0]      frame_height_q;
	logic [chm_pkg::WEFF_W-1:0]     w_eff;
	logic [chm_pkg::CFG_W-1:0]      h_eff;

	logic [chm_pkg::COL_W-1:0]      in_col_q;
	logic [chm_pkg::IN_ROW_W-1:0]   in_row_q;
	logic [chm_pkg::COL_W-1:0]      out_col_q;
	logic [chm_pkg::OUT_ROW_W-1:0]  out_row_q;

	logic [chm_pkg::WEFF_W-1:0]     in_col_inc;
	logic [chm_pkg::WEFF_W-1:0]     out_col_inc;
	logic [chm_pkg::CFG_W-1:0]      out_row_inc;
	logic                           in_wrap;
	logic                           out_wrap;
	logic                           out_row_end;
	logic                           emit;
	logic                           border;
	logic                           last;

	logic                           acc;
	chm_pkg::uv_t                   sample;
	chm_pkg::window_t               window;
	chm_pkg::plane_win_t            u_win;
	chm_pkg::plane_win_t            v_win;
	chm_pkg::lane_res_t             u_res;
	chm_pkg::lane_res_t             v_res;

	logic                           v_s1, v_s2, v_s3, v_s4, v_s5;
	chm_pkg::ctrl_t                 ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;

	logic [chm_pkg::QCNT_W-1:0]     pending_q;
	logic                           pop;
	logic                           drop;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= chm_pkg::FRAME_WIDTH_RST;
			frame_height_q <= chm_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				chm_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				chm_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
			endcase
		end
	end

	// Zero counts as one, oversize is clamped.
	always_comb begin
		priority if (frame_width_q == '0) begin
			w_eff = chm_pkg::WEFF_W'(1);
		end else if (32'(frame_width_q) > chm_pkg::MAX_WIDTH) begin
			w_eff = chm_pkg::WEFF_W'(chm_pkg::MAX_WIDTH);
		end else begin
			w_eff = chm_pkg::WEFF_W'(frame_width_q);
		end
		priority if (frame_height_q == '0) begin
			h_eff = chm_pkg::CFG_W'(1);
		end else if (32'(frame_height_q) > chm_pkg::HEIGHT_LIMIT) begin
			h_eff = chm_pkg::CFG_W'(chm_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// Position tracking, decided when the item is accepted
	assign in_col_inc  = {1'b0, in_col_q} + chm_pkg::WEFF_W'(1);
	assign out_col_inc = {1'b0, out_col_q} + chm_pkg::WEFF_W'(1);
	assign out_row_inc = chm_pkg::CFG_W'(out_row_q) + chm_pkg::CFG_W'(1);
	assign in_wrap     = (in_col_inc >= w_eff);
	assign out_wrap    = (out_col_inc >= w_eff);
	assign out_row_end = (out_row_inc >= h_eff);
	assign emit        = (in_row_q >= chm_pkg::IN_ROW_W'(2))
		|| ((in_row_q == chm_pkg::IN_ROW_W'(1)) && (in_col_q != '0));
	assign border      = (out_col_q == '0) || out_wrap || (out_row_q == '0) || out_row_end;
	assign last        = out_wrap && out_row_end;

	assign pixel.ready = (pending_q < chm_pkg::QCNT_W'(chm_pkg::QUEUE_DEPTH));
	assign acc         = pixel.valid && pixel.ready;
	assign sample      = (pixel.req_type == chm_pkg::REQ_PIXEL) ? {pixel.u_in, pixel.v_in} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + chm_pkg::IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_inc[chm_pkg::COL_W-1:0];
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + chm_pkg::OUT_ROW_W'(1);
					end else begin
						out_col_q <= out_col_inc[chm_pkg::COL_W-1:0];
					end
				end
			end
		end
	end

	// Control pipeline alongside the line store and median lanes
	always_ff @(posedge clk) begin
		ctrl_s1 <= '{emit: emit, border: border, last: last};
		ctrl_s2 <= ctrl_s1;
		ctrl_s3 <= ctrl_s2;
		ctrl_s4 <= ctrl_s3;
		ctrl_s5 <= ctrl_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	chm_line_store u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.col    (in_col_q),
		.sample (sample),
		.window (window)
	);

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			u_win[i] = window[i][2*chm_pkg::SAMPLE_W-1:chm_pkg::SAMPLE_W];
			v_win[i] = window[i][chm_pkg::SAMPLE_W-1:0];
		end
	end

	chm_median_lane u_lane_u (
		.clk (clk),
		.win (u_win),
		.res (u_res)
	);

	chm_median_lane u_lane_v (
		.clk (clk),
		.win (v_win),
		.res (v_res)
	);

	chm_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (v_s5),
		.ctrl   (ctrl_s5),
		.u_res  (u_res),
		.v_res  (v_res),
		.pop    (pop),
		.result (result)
	);

	// Items in flight plus queued results; items with no result leave at s5.
	assign drop = v_s5 && !ctrl_s5.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + chm_pkg::QCNT_W'(acc) - chm_pkg::QCNT_W'(drop)
				- chm_pkg::QCNT_W'(pop);
		end
	end

	`CHM_ASSERT_NEXT(a_frame_end_clears, acc && emit && last, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "frame end did not clear positions")
	`CHM_ASSERT_NEXT(a_push_shows, v_s5 && ctrl_s5.emit, result.valid, "queued item not offered")
	`CHM_ASSERT_NOW(a_valid_counted, result.valid, pending_q != '0, "result offered with no pending item")

endmodule
